/* design/mek_pkg.sv */
// mek_pkg: shared types, constants and helpers of the max-flow unit.
// No dependencies; imported by mek_ctrl, mek_dp and max_flow_edmonds_karp_unit.
`default_nettype none
package mek_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam logic [19:0] PATH_CAP = 20'hfffff;

  // command codes carried on tuser
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_SINK   = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_CLR, ST_BFS_INIT, ST_POP, ST_POP_W, ST_SCAN,
    ST_MIN_P, ST_MIN_PW, ST_MIN_R, ST_UPD_P, ST_UPD_PW, ST_UPD_F, ST_UPD_B, ST_FINISH
  } mek_state_e;

  typedef enum logic [3:0] {
    OP_ACCEPT, OP_ADD_RD, OP_ADD_WR, OP_CLR, OP_BFS_INIT, OP_POP, OP_POP_W, OP_SCAN,
    OP_WALK_P, OP_PW, OP_MIN_R, OP_UPD_F, OP_UPD_B, OP_FINISH
  } mek_op_e;

  typedef struct packed {
    logic       in_acc;
    logic [1:0] cmd;
    logic       add_ok;
    logic       run_ok;
    logic       clr_last;
    logic       q_empty;
    logic       dst_vis;
    logic       u_is_dst;
    logic       scan_done;
    logic       p_is_src;
    logic       out_free;
  } mek_status_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffffffff : s[31:0];
  endfunction

endpackage
`default_nettype wire

/* design/mek_ctrl.sv */
// mek_ctrl: sequencer of the max-flow unit (add, clear, search, augment).
// Depends on mek_pkg; drives mek_dp through one op code per state.
`default_nettype none
module mek_ctrl
  import mek_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  mek_status_t status_i,
  output mek_op_e     op_o
);

  mek_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (status_i.in_acc) begin
          case (status_i.cmd)
            CMD_ADD:   state_d = status_i.add_ok ? ST_ADD_RD : ST_IDLE;
            CMD_RUN:   state_d = status_i.run_ok ? ST_BFS_INIT : ST_FINISH;
            CMD_CLEAR: state_d = ST_CLR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD:   state_d = ST_ADD_WR;
      ST_ADD_WR:   state_d = ST_IDLE;
      ST_CLR:      state_d = status_i.clr_last ? ST_IDLE : ST_CLR;
      ST_BFS_INIT: state_d = ST_POP;
      ST_POP: begin
        if (status_i.q_empty) state_d = status_i.dst_vis ? ST_MIN_P : ST_FINISH;
        else state_d = ST_POP_W;
      end
      ST_POP_W:    state_d = status_i.u_is_dst ? ST_MIN_P : ST_SCAN;
      ST_SCAN:     state_d = status_i.scan_done ? ST_POP : ST_SCAN;
      ST_MIN_P:    state_d = ST_MIN_PW;
      ST_MIN_PW:   state_d = ST_MIN_R;
      ST_MIN_R:    state_d = status_i.p_is_src ? ST_UPD_P : ST_MIN_P;
      ST_UPD_P:    state_d = ST_UPD_PW;
      ST_UPD_PW:   state_d = ST_UPD_F;
      ST_UPD_F:    state_d = ST_UPD_B;
      ST_UPD_B:    state_d = status_i.p_is_src ? ST_BFS_INIT : ST_UPD_P;
      ST_FINISH:   state_d = status_i.out_free ? ST_IDLE : ST_FINISH;
      default:     state_d = ST_IDLE;
    endcase
  end

  // op per state
  always_comb begin
    case (state_q)
      ST_IDLE:     op_o = OP_ACCEPT;
      ST_ADD_RD:   op_o = OP_ADD_RD;
      ST_ADD_WR:   op_o = OP_ADD_WR;
      ST_CLR:      op_o = OP_CLR;
      ST_BFS_INIT: op_o = OP_BFS_INIT;
      ST_POP:      op_o = OP_POP;
      ST_POP_W:    op_o = OP_POP_W;
      ST_SCAN:     op_o = OP_SCAN;
      ST_MIN_P:    op_o = OP_WALK_P;
      ST_MIN_PW:   op_o = OP_PW;
      ST_MIN_R:    op_o = OP_MIN_R;
      ST_UPD_P:    op_o = OP_WALK_P;
      ST_UPD_PW:   op_o = OP_PW;
      ST_UPD_F:    op_o = OP_UPD_F;
      ST_UPD_B:    op_o = OP_UPD_B;
      ST_FINISH:   op_o = OP_FINISH;
      default:     op_o = OP_ACCEPT;
    endcase
  end

  // reset starts with a clearing pass over the matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLR;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

/* design/mek_dp.sv */
// mek_dp: datapath of the max-flow unit: residual matrix, parent and queue memories,
// search counters, path minimum, flow total and output register. Depends on mek_pkg.
`default_nettype none
module mek_dp
  import mek_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  mek_op_e      op_i,
  output mek_status_t  status_o,
  input  wire  [6:0]   cfg_src_i,
  input  wire  [6:0]   cfg_dst_i,
  input  wire  [6:0]   cfg_count_i,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [39:0]  s_axis_tdata_i,  // from_node[6:0], to_node[13:7], capacity[33:14]
  input  wire  [1:0]   s_axis_tuser_i,  // command[1:0]
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o   // max_flow[31:0]
);

  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW = 2 * IW;
  localparam int RDEPTH = 1 << AW;

  function automatic logic [IW-1:0] nidx(input logic [NW-1:0] v);
    return IW'(v - NW'(1));
  endfunction

  // memories
  logic [31:0]   res_mem [RDEPTH];
  logic [NW-1:0] par_mem [MAX_NODES];
  logic [NW-1:0] que_mem [MAX_NODES];
  logic [31:0]   res_rdata_q;
  logic [NW-1:0] par_rdata_q, que_rdata_q;

  // registers
  logic [6:0]     from_q, to_q;
  logic [19:0]    cap_q;
  logic [AW-1:0]  clr_cnt_q;
  logic [NW-1:0]  head_q, tail_q, u_q, chk_v_q, walk_v_q, p_q;
  logic [NW:0]    scan_v_q;
  logic           chk_vld_q;
  logic [MAX_NODES-1:0] visited_q;
  logic [19:0]    amount_q;
  logic [31:0]    flow_q;
  logic           out_vld_q;
  logic [31:0]    out_data_q;

  logic [NW-1:0] n_node, src, dst;
  logic          in_acc, add_ok, run_ok, issue, hit;
  logic [6:0]    in_from, in_to;
  logic [19:0]   in_cap;

  assign in_from = s_axis_tdata_i[6:0];
  assign in_to   = s_axis_tdata_i[13:7];
  assign in_cap  = s_axis_tdata_i[33:14];

  // effective node count and endpoints
  assign n_node = (32'(cfg_count_i) > MAX_NODES) ? NW'(MAX_NODES) : NW'(cfg_count_i);
  assign src    = NW'(cfg_src_i);
  assign dst    = NW'(cfg_dst_i);

  assign s_axis_tready_o = (op_i == OP_ACCEPT);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign add_ok = (in_from != 7'd0) && (32'(in_from) <= MAX_NODES) &&
                  (in_to != 7'd0) && (32'(in_to) <= MAX_NODES);
  assign run_ok = (cfg_src_i != 7'd0) && (cfg_dst_i != 7'd0) &&
                  (32'(cfg_src_i) <= 32'(n_node)) && (32'(cfg_dst_i) <= 32'(n_node)) &&
                  (cfg_src_i != cfg_dst_i);

  assign issue = (op_i == OP_SCAN) && (scan_v_q <= {1'b0, n_node});
  assign hit   = (op_i == OP_SCAN) && chk_vld_q && (res_rdata_q != 32'd0) &&
                 !visited_q[nidx(chk_v_q)] && (32'(tail_q) < MAX_NODES);

  always_comb begin
    status_o.in_acc    = in_acc;
    status_o.cmd       = s_axis_tuser_i;
    status_o.add_ok    = add_ok;
    status_o.run_ok    = run_ok;
    status_o.clr_last  = &clr_cnt_q;
    status_o.q_empty   = (head_q == tail_q);
    status_o.dst_vis   = visited_q[nidx(dst)];
    status_o.u_is_dst  = (que_rdata_q == dst);
    status_o.scan_done = (scan_v_q > {1'b0, n_node}) && !chk_vld_q;
    status_o.p_is_src  = (p_q == src);
    status_o.out_free  = !out_vld_q || m_axis_tready_i;
  end

  // residual matrix port selection
  logic          res_we, res_re;
  logic [AW-1:0] res_waddr, res_raddr;
  logic [31:0]   res_wdata;

  always_comb begin
    res_we    = 1'b0;
    res_re    = 1'b0;
    res_waddr = '0;
    res_raddr = '0;
    res_wdata = '0;
    case (op_i)
      OP_ADD_RD: begin
        res_re    = 1'b1;
        res_raddr = {IW'(from_q - 7'd1), IW'(to_q - 7'd1)};
      end
      OP_ADD_WR: begin
        res_we    = 1'b1;
        res_waddr = {IW'(from_q - 7'd1), IW'(to_q - 7'd1)};
        res_wdata = sat_add(res_rdata_q, {12'd0, cap_q});
      end
      OP_CLR: begin
        res_we    = 1'b1;
        res_waddr = clr_cnt_q;
      end
      OP_SCAN: begin
        res_re    = issue;
        res_raddr = {nidx(u_q), nidx(NW'(scan_v_q))};
      end
      OP_PW: begin
        res_re    = 1'b1;
        res_raddr = {nidx(par_rdata_q), nidx(walk_v_q)};
      end
      OP_UPD_F: begin
        res_we    = 1'b1;
        res_waddr = {nidx(p_q), nidx(walk_v_q)};
        res_wdata = res_rdata_q - {12'd0, amount_q};
        res_re    = 1'b1;
        res_raddr = {nidx(walk_v_q), nidx(p_q)};
      end
      OP_UPD_B: begin
        res_we    = 1'b1;
        res_waddr = {nidx(walk_v_q), nidx(p_q)};
        res_wdata = sat_add(res_rdata_q, {12'd0, amount_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    if (res_re) res_rdata_q <= res_mem[res_raddr];
  end

  // parent and queue memories: written at search start and on each new node
  logic          pq_we;
  logic [IW-1:0] pq_waddr_par, pq_waddr_que;
  logic [NW-1:0] par_wdata, que_wdata;

  always_comb begin
    pq_we        = 1'b0;
    pq_waddr_par = '0;
    pq_waddr_que = '0;
    par_wdata    = '0;
    que_wdata    = '0;
    if (op_i == OP_BFS_INIT) begin
      pq_we        = 1'b1;
      pq_waddr_par = nidx(src);
      pq_waddr_que = '0;
      par_wdata    = src;
      que_wdata    = src;
    end else if (hit) begin
      pq_we        = 1'b1;
      pq_waddr_par = nidx(chk_v_q);
      pq_waddr_que = tail_q[IW-1:0];
      par_wdata    = u_q;
      que_wdata    = chk_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pq_we) begin
      par_mem[pq_waddr_par] <= par_wdata;
      que_mem[pq_waddr_que] <= que_wdata;
    end
    if (op_i == OP_WALK_P) par_rdata_q <= par_mem[nidx(walk_v_q)];
    if (op_i == OP_POP) que_rdata_q <= que_mem[head_q[IW-1:0]];
  end

  // payload latch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      from_q <= in_from;
      to_q   <= in_to;
      cap_q  <= in_cap;
    end
  end

  // search, walk and flow control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      u_q        <= '0;
      chk_v_q    <= '0;
      scan_v_q   <= '0;
      chk_vld_q  <= 1'b0;
      visited_q  <= '0;
      walk_v_q   <= '0;
      p_q        <= '0;
      amount_q   <= '0;
      flow_q     <= '0;
    end else begin
      case (op_i)
        OP_ACCEPT: if (in_acc && s_axis_tuser_i == CMD_RUN) flow_q <= '0;
        OP_CLR: clr_cnt_q <= clr_cnt_q + AW'(1);
        OP_BFS_INIT: begin
          // only the source is marked at search start
          visited_q <= MAX_NODES'(1) << nidx(src);
          head_q    <= '0;
          tail_q    <= NW'(1);
        end
        OP_POP: begin
          if (head_q != tail_q) head_q <= head_q + NW'(1);
          walk_v_q <= dst;
          amount_q <= PATH_CAP;
        end
        OP_POP_W: begin
          u_q       <= que_rdata_q;
          scan_v_q  <= (NW + 1)'(1);
          chk_vld_q <= 1'b0;
        end
        OP_SCAN: begin
          chk_vld_q <= issue;
          chk_v_q   <= NW'(scan_v_q);
          if (issue) scan_v_q <= scan_v_q + (NW + 1)'(1);
          if (hit) begin
            visited_q[nidx(chk_v_q)] <= 1'b1;
            tail_q <= tail_q + NW'(1);
          end
        end
        OP_PW: p_q <= par_rdata_q;
        OP_MIN_R: begin
          if (res_rdata_q < {12'd0, amount_q}) amount_q <= res_rdata_q[19:0];
          walk_v_q <= (p_q == src) ? dst : p_q;
        end
        OP_UPD_B: begin
          walk_v_q <= p_q;
          if (p_q == src) flow_q <= sat_add(flow_q, {12'd0, amount_q});
        end
        default: ;
      endcase
    end
  end

  // output word register: loaded at finish when free, dropped once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else if ((op_i == OP_FINISH) && (!out_vld_q || m_axis_tready_i)) begin
      out_vld_q  <= 1'b1;
      out_data_q <= flow_q;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

/* design/max_flow_edmonds_karp_unit.sv */
// max_flow_edmonds_karp_unit: top level with the APB register bank, sequencer and datapath.
// Depends on mek_pkg, mek_ctrl and mek_dp.
//
//  channel  | dir | words
//  s_axis   | in  | tuser command; tdata from_node, to_node, capacity
//  m_axis   | out | tdata max_flow, one word per run command
//  apb      | in  | source_node @0x0, sink_node @0x4, node_count @0x8
//
// Add: read, then saturating write of one matrix word. Clear: all 2**(2*clog2(MAX_NODES))
// matrix words are zeroed, one matrix word per cycle.
// Run: each search pops queued nodes and scans their rows, then walks the path twice
// (minimum, then update); the single read port of the residual matrix sets the pace.
// After reset the same clearing pass runs with s_axis_tready_o low.
// A waiting result does not block the next word; a finished run holds until m_axis is free.
`default_nettype none
module max_flow_edmonds_karp_unit
  import mek_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,  // from_node[6:0], to_node[13:7], capacity[33:14]
  input  wire  [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // max_flow[31:0]
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0] src_q, dst_q, count_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= 7'd1;
      dst_q   <= 7'd64;
      count_q <= 7'd64;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_SOURCE: src_q   <= pwdata[6:0];
        REG_SINK:   dst_q   <= pwdata[6:0];
        REG_COUNT:  count_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SOURCE: prdata = {25'd0, src_q};
      REG_SINK:   prdata = {25'd0, dst_q};
      REG_COUNT:  prdata = {25'd0, count_q};
      default:    prdata = 32'd0;
    endcase
  end

  mek_op_e     op;
  mek_status_t status;

  mek_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  mek_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .status_o        (status),
    .cfg_src_i       (src_q),
    .cfg_dst_i       (dst_q),
    .cfg_count_i     (count_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire
